[hw/rtl/csq_pkg.sv]
// ----------------------------------------------------------------------------
// csq_pkg: shared types and constants for the semaphore bank
// Sizes of the bank, request and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package csq_pkg;

	// bank geometry
	localparam int NUM_SEMAPHORES = 16;
	localparam int QUEUE_DEPTH    = 8;
	localparam int NUM_TASKS      = 16;

	// derived widths
	localparam int IDX_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int NF_W   = $clog2(NUM_SEMAPHORES + 1);
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = FILL_W + 1;
	localparam int QMEM_DEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
	localparam int ADDR_W = (QMEM_DEPTH > 1) ? $clog2(QMEM_DEPTH) : 1;

	// fixed field widths
	localparam int TASK_W = 4;
	localparam int NUM_W  = 4;
	localparam int CNT_W  = 8;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_WAIT   = 2'd1,
		REQ_SIGNAL = 2'd2,
		REQ_CLOSE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_DONE    = 3'd0,
		STAT_BLOCKED = 3'd1,
		STAT_WOKEN   = 3'd2,
		STAT_BAD     = 3'd3,
		STAT_NOFREE  = 3'd4,
		STAT_FULL    = 3'd5,
		STAT_EMPTY   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;     // register the accepted request
		logic exec_fire;   // evaluate the request and commit it
		logic drain_fire;  // present one dequeued task
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;    // output register can take a result
		logic needs_read;  // request dequeues from the wait queue
		logic more;        // close still has queued tasks
	} dp_status_t;

endpackage

[hw/rtl/counting_semaphore_wait_queue.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue: counting semaphore bank with wait queues
// Create, wait, signal and close requests on a bank of semaphores, each
// with a FIFO of blocked task numbers kept in one shared memory.
// ----------------------------------------------------------------------------
// One request is taken at a time. Create, wait, a signal that wakes no task
// and a close of an empty queue are accepted, then executed, which loads the
// output register. A waking signal and a close of a non-empty queue go on to
// a drain step per woken task: each woken task is one registered read of the
// wait queue memory. The next request is taken while the last result still
// waits in the output register. A stalled output holds the block in its
// execute or drain step. No clearing pass runs after reset; queue entries
// are only read after they were written.
module counting_semaphore_wait_queue
	import csq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // sem_index[7:0], init_value[15:8], task_id[19:16], zero
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // sem_number[3:0], woken_task[7:4]
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast
);

	ctrl_cmd_t         cmd;
	dp_status_t        dp_status;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [TASK_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [TASK_W-1:0] ram_rdata;

	// sequencer
	csq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// counts, pointers and result register
	csq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.dp_status (dp_status),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// wait queue storage
	csq_ram #(
		.WIDTH (TASK_W),
		.DEPTH (QMEM_DEPTH)
	) u_qmem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// a request is executed before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one not executed");

	// a push and a dequeue never share a cycle
	a_no_push_and_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("wait queue written and read together");

	// a dequeue keeps the block busy until its task is reported
	a_read_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> !s_tready)
		else $error("request taken while a dequeued task is pending");

	// a queued task is reported as a blocked wait
	a_blocked_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec_fire && ram_we |=> m_tvalid && m_tuser == STAT_BLOCKED)
		else $error("queued task not reported blocked");

endmodule

[hw/rtl/csq_ram.sv]
// ----------------------------------------------------------------------------
// csq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module csq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/csq_ctrl.sv]
// ----------------------------------------------------------------------------
// csq_ctrl: request sequencer
// Takes one request, lets the datapath execute it, and steps through the
// dequeues of a waking signal or a close one result at a time.
// ----------------------------------------------------------------------------
module csq_ctrl
	import csq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t dp_status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (dp_status.out_free) begin
					cmd.exec_fire = 1'b1;
					state_d       = dp_status.needs_read ? ST_DRAIN : ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (dp_status.out_free) begin
					cmd.drain_fire = 1'b1;
					state_d        = dp_status.more ? ST_DRAIN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/csq_dp.sv]
// ----------------------------------------------------------------------------
// csq_dp: semaphore bank datapath
// Holds counts, queue pointers and the create counter, decides the outcome
// of a request, drives the wait queue memory and the output register.
// ----------------------------------------------------------------------------
module csq_dp
	import csq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [23:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        dp_status,
	// wait queue memory
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [TASK_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [TASK_W-1:0] ram_rdata,
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	// captured request
	req_t               req_q;
	logic [7:0]         idx_q;
	logic signed [7:0]  init_q;
	logic [TASK_W-1:0]  task_q;

	// bank state
	logic signed [CNT_W-1:0] sem_count_q [NUM_SEMAPHORES];
	logic [PTR_W-1:0]        head_q [NUM_SEMAPHORES];
	logic [FILL_W-1:0]       fill_q [NUM_SEMAPHORES];
	logic [NF_W-1:0]         next_free_q;

	// output register
	logic              m_valid_q;
	status_t           status_q;
	logic [NUM_W-1:0]  num_q;
	logic [TASK_W-1:0] woken_q;
	logic              last_q;

	// selected semaphore
	logic [IDX_W-1:0]        sel;
	logic                    idx_ok;
	logic                    task_ok;
	logic signed [CNT_W-1:0] cnt;
	logic signed [CNT_W-1:0] cnt_dec;
	logic signed [CNT_W-1:0] cnt_inc;
	logic [PTR_W-1:0]        head;
	logic [FILL_W-1:0]       fill;
	logic [PTR_W-1:0]        head_next;
	logic [SUM_W-1:0]        tail_sum;
	logic [PTR_W-1:0]        tail;
	logic [ADDR_W-1:0]       row_base;

	// decision
	status_t                 r_status;
	logic [NUM_W-1:0]        r_num;
	logic [TASK_W-1:0]       r_task;
	logic                    cnt_we;
	logic [IDX_W-1:0]        cnt_widx;
	logic signed [CNT_W-1:0] cnt_new;
	logic                    needs_read;
	logic                    q_push;
	logic                    create_inc;
	logic                    more;
	logic                    out_load;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_t'(s_tuser);
			idx_q  <= s_tdata[7:0];
			init_q <= s_tdata[15:8];
			task_q <= s_tdata[19:16];
		end
	end

	// lookups of the addressed semaphore
	assign sel     = idx_q[IDX_W-1:0];
	assign idx_ok  = 9'(idx_q) < 9'(NUM_SEMAPHORES);
	assign task_ok = 9'(task_q) < 9'(NUM_TASKS);
	assign cnt     = sem_count_q[sel];
	assign head    = head_q[sel];
	assign fill    = fill_q[sel];
	assign cnt_dec = (cnt == -8'sd128) ? cnt : cnt - 8'sd1;
	assign cnt_inc = (cnt == 8'sd127) ? cnt : cnt + 8'sd1;

	// ring pointer arithmetic, sum stays below twice the depth
	assign head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
	assign tail_sum  = SUM_W'(head) + SUM_W'(fill);
	assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign row_base  = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH);

	// outcome of the captured request
	always_comb begin
		r_status   = STAT_DONE;
		r_num      = '0;
		r_task     = '0;
		cnt_we     = 1'b0;
		cnt_widx   = sel;
		cnt_new    = cnt;
		needs_read = 1'b0;
		q_push     = 1'b0;
		create_inc = 1'b0;
		case (req_q)
			REQ_CREATE: begin
				if (init_q[7]) begin
					r_status = STAT_BAD;
				end else if (next_free_q >= NF_W'(NUM_SEMAPHORES)) begin
					r_status = STAT_NOFREE;
				end else begin
					cnt_we     = 1'b1;
					cnt_widx   = next_free_q[IDX_W-1:0];
					cnt_new    = init_q;
					r_num      = NUM_W'(next_free_q);
					create_inc = 1'b1;
				end
			end
			REQ_WAIT: begin
				cnt_new = cnt_dec;
				if (!idx_ok || !task_ok) begin
					r_status = STAT_BAD;
				end else if (!cnt_dec[CNT_W-1]) begin
					cnt_we = 1'b1;
				end else if (fill >= FILL_W'(QUEUE_DEPTH)) begin
					r_status = STAT_FULL;
				end else begin
					cnt_we   = 1'b1;
					q_push   = 1'b1;
					r_status = STAT_BLOCKED;
					r_task   = task_q;
				end
			end
			REQ_SIGNAL: begin
				cnt_new = cnt_inc;
				if (!idx_ok) begin
					r_status = STAT_BAD;
				end else if (!cnt_inc[CNT_W-1] && cnt_inc != '0) begin
					cnt_we = 1'b1;
				end else if (fill == '0) begin
					r_status = STAT_EMPTY;
				end else begin
					cnt_we     = 1'b1;
					needs_read = 1'b1;
				end
			end
			REQ_CLOSE: begin
				cnt_new = '0;
				if (!idx_ok) begin
					r_status = STAT_BAD;
				end else begin
					cnt_we     = 1'b1;
					needs_read = (fill != '0);
				end
			end
			default: begin
				r_status = STAT_BAD;
			end
		endcase
	end

	// close keeps draining while tasks remain
	assign more = (req_q == REQ_CLOSE) && (fill != '0);

	// queue memory access
	assign ram_we    = cmd.exec_fire && q_push;
	assign ram_waddr = row_base + ADDR_W'(tail);
	assign ram_wdata = task_q;
	assign ram_re    = (cmd.exec_fire && needs_read) || (cmd.drain_fire && more);
	assign ram_raddr = row_base + ADDR_W'(head);

	// bank state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				sem_count_q[i] <= '0;
				head_q[i]      <= '0;
				fill_q[i]      <= '0;
			end
			next_free_q <= '0;
		end else begin
			if (cmd.exec_fire && cnt_we) begin
				sem_count_q[cnt_widx] <= cnt_new;
			end
			if (cmd.exec_fire && create_inc) begin
				next_free_q <= next_free_q + NF_W'(1);
			end
			if (ram_we) begin
				fill_q[sel] <= fill + FILL_W'(1);
			end
			if (ram_re) begin
				head_q[sel] <= head_next;
				fill_q[sel] <= fill - FILL_W'(1);
			end
		end
	end

	// output register
	assign out_load = (cmd.exec_fire && !needs_read) || cmd.drain_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_fire) begin
			status_q <= STAT_WOKEN;
			num_q    <= '0;
			woken_q  <= ram_rdata;
			last_q   <= !more;
		end else if (cmd.exec_fire && !needs_read) begin
			status_q <= r_status;
			num_q    <= r_num;
			woken_q  <= r_task;
			last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {woken_q, num_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	assign dp_status.out_free   = !m_valid_q || m_tready;
	assign dp_status.needs_read = needs_read;
	assign dp_status.more       = more;

endmodule

[verif/tb_counting_semaphore_wait_queue.sv]
// ----------------------------------------------------------------------------
// tb_counting_semaphore_wait_queue: self-checking bench for the semaphore bank
// Directed and random create, wait, signal and close requests go into the
// request stream. A behavioral copy of the bank predicts every result, and
// each result transaction is checked field by field against the oldest
// prediction. The sender runs in bursts, the receiver stalls on its own
// pattern, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_wait_queue
	import csq_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 144;

	typedef struct {
		status_t    status;
		logic [3:0] sem_number;
		logic [3:0] task_num;
		logic       last;
	} sem_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// behavioral copy of the bank
	logic signed [7:0] sem_level [NUM_SEMAPHORES];
	logic [3:0]        waiter_fifo [NUM_SEMAPHORES][QUEUE_DEPTH];
	int                waiter_head [NUM_SEMAPHORES];
	int                waiter_fill [NUM_SEMAPHORES];
	int                next_sem_number = 0;

	sem_result_t pending_results[$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	bit          hold_request   = 1'b0;

	counting_semaphore_wait_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void queue_result(status_t st, int num, int tnum, bit last);
		sem_result_t r;
		r.status     = st;
		r.sem_number = num[3:0];
		r.task_num   = tnum[3:0];
		r.last       = last;
		pending_results.push_back(r);
	endfunction

	// update the bank copy for one accepted request and queue its results
	function automatic void predict_request(req_t req, logic [7:0] idx,
			logic signed [7:0] init, logic [3:0] tid);
		int lvl;
		int s;
		int t;
		s = idx;
		if (req == REQ_CREATE) begin
			if (init < 0)
				queue_result(STAT_BAD, 0, 0, 1'b1);
			else if (next_sem_number >= NUM_SEMAPHORES)
				queue_result(STAT_NOFREE, 0, 0, 1'b1);
			else begin
				sem_level[next_sem_number] = init;
				queue_result(STAT_DONE, next_sem_number, 0, 1'b1);
				next_sem_number++;
			end
		end else if (s >= NUM_SEMAPHORES) begin
			queue_result(STAT_BAD, 0, 0, 1'b1);
		end else if (req == REQ_WAIT) begin
			lvl = sem_level[s];
			lvl = (lvl > -128) ? lvl - 1 : -128;
			if (int'(tid) >= NUM_TASKS)
				queue_result(STAT_BAD, 0, 0, 1'b1);
			else if (lvl >= 0) begin
				sem_level[s] = lvl[7:0];
				queue_result(STAT_DONE, 0, 0, 1'b1);
			end else if (waiter_fill[s] >= QUEUE_DEPTH)
				queue_result(STAT_FULL, 0, 0, 1'b1);
			else begin
				sem_level[s] = lvl[7:0];
				waiter_fifo[s][(waiter_head[s] + waiter_fill[s]) % QUEUE_DEPTH] = tid;
				waiter_fill[s]++;
				queue_result(STAT_BLOCKED, 0, tid, 1'b1);
			end
		end else if (req == REQ_SIGNAL) begin
			lvl = sem_level[s];
			lvl = (lvl < 127) ? lvl + 1 : 127;
			if (lvl > 0) begin
				sem_level[s] = lvl[7:0];
				queue_result(STAT_DONE, 0, 0, 1'b1);
			end else if (waiter_fill[s] == 0)
				queue_result(STAT_EMPTY, 0, 0, 1'b1);
			else begin
				sem_level[s] = lvl[7:0];
				t = waiter_fifo[s][waiter_head[s]];
				waiter_head[s] = (waiter_head[s] + 1) % QUEUE_DEPTH;
				waiter_fill[s]--;
				queue_result(STAT_WOKEN, 0, t, 1'b1);
			end
		end else begin
			// close wakes every waiter, oldest first
			sem_level[s] = '0;
			if (waiter_fill[s] == 0)
				queue_result(STAT_DONE, 0, 0, 1'b1);
			while (waiter_fill[s] != 0) begin
				t = waiter_fifo[s][waiter_head[s]];
				waiter_head[s] = (waiter_head[s] + 1) % QUEUE_DEPTH;
				waiter_fill[s]--;
				queue_result(STAT_WOKEN, 0, t, waiter_fill[s] == 0);
			end
		end
	endfunction

	// send one request transaction; the sender runs in bursts with gaps
	task automatic send_request(input req_t req, input int idx, input int init,
			input int tid);
		logic [7:0] idx8;
		logic [7:0] init8;
		logic [3:0] tid4;
		int gap;
		idx8  = idx[7:0];
		init8 = init[7:0];
		tid4  = tid[3:0];
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = {4'b0, tid4, init8, idx8};
		s_tuser  = req;
		do @(posedge clk); while (!s_tready);
		predict_request(req, idx8, $signed(init8), tid4);
	endtask

	// random request, biased to a few semaphores so queues grow deep
	task automatic send_random_request();
		int pick;
		int idx;
		req_t req;
		pick = $urandom_range(99);
		if (pick < 5)
			req = REQ_CREATE;
		else if (pick < 52)
			req = REQ_WAIT;
		else if (pick < 88)
			req = REQ_SIGNAL;
		else
			req = REQ_CLOSE;
		pick = $urandom_range(19);
		if (pick == 0)
			idx = $urandom_range(255);
		else if (pick < 11)
			idx = $urandom_range(3);
		else
			idx = $urandom_range(NUM_SEMAPHORES - 1);
		if (req == REQ_CREATE && $urandom_range(1) == 0)
			send_request(req, idx, $urandom_range(0, 3), $urandom_range(15));
		else
			send_request(req, idx, $urandom_range(255), $urandom_range(15));
	endtask

	// field extremes, every request type, saturation and bad indexes
	task automatic test_directed();
		send_request(REQ_CREATE, 0, -128, 0);
		send_request(REQ_CREATE, 255, -1, 15);
		send_request(REQ_CREATE, 0, 0, 0);     // sem 0, count 0
		send_request(REQ_CREATE, 0, 127, 0);   // sem 1, count at top
		send_request(REQ_CREATE, 0, 1, 0);     // sem 2
		send_request(REQ_SIGNAL, 1, 0, 0);     // saturates at 127
		send_request(REQ_WAIT, 0, 0, 15);
		send_request(REQ_WAIT, 0, 0, 0);
		send_request(REQ_SIGNAL, 0, 0, 0);     // wakes task 15
		send_request(REQ_WAIT, 2, 0, 3);       // takes the last unit
		send_request(REQ_CLOSE, 0, 0, 0);      // one waiter, last set
		send_request(REQ_CLOSE, 2, 0, 0);      // empty queue
		send_request(REQ_SIGNAL, 4, 0, 0);     // signal on a fresh semaphore
		send_request(REQ_WAIT, 16, 0, 1);
		send_request(REQ_SIGNAL, 255, 0, 0);
		send_request(REQ_CLOSE, 128, 0, 0);
		send_request(REQ_WAIT, 1, -1, 10);
	endtask

	// fill one queue to the top, overflow it, wrap it and drain it by close
	task automatic test_queue_full();
		for (int i = 1; i <= QUEUE_DEPTH + 1; i++)
			send_request(REQ_WAIT, 3, 0, i);
		send_request(REQ_SIGNAL, 3, 0, 0);
		send_request(REQ_WAIT, 3, 0, 12);
		send_request(REQ_CLOSE, 3, 0, 0);
	endtask

	// receiver holds off while the sender keeps offering requests
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (30) send_random_request();
	endtask

	task automatic test_random();
		repeat (RANDOM_ITEMS) send_random_request();
	endtask

	// use up the bank, then ask for more; a negative value still reports bad
	task automatic test_bank_exhausted();
		while (next_sem_number < NUM_SEMAPHORES)
			send_request(REQ_CREATE, 0, $urandom_range(127), 0);
		send_request(REQ_CREATE, 0, 0, 0);
		send_request(REQ_CREATE, 0, -5, 0);
		send_request(REQ_CREATE, 0, 127, 0);
	endtask

	// receiver: stalls on a randomly chosen pattern, plus the long hold-off
	always @(negedge clk) begin : receiver
		int cycle_cnt;
		int mode;
		int hold_left;
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (cycle_cnt % 64 == 0)
			mode = $urandom_range(3);
		cycle_cnt++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			case (mode)
				0: m_tready = 1'b1;
				1: m_tready = ($urandom_range(9) < 7);
				2: m_tready = ($urandom_range(9) < 3);
				default: m_tready = (cycle_cnt % 4 == 0);
			endcase
		end
	end

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin : result_check
		sem_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d data=%h last=%b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
				if (m_tdata[3:0] !== want.sem_number)
					report_mismatch($sformatf("sem_number %0d, want %0d",
						m_tdata[3:0], want.sem_number));
				if (m_tdata[7:4] !== want.task_num)
					report_mismatch($sformatf("woken_task %0d, want %0d",
						m_tdata[7:4], want.task_num));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SEMAPHORES; i++) begin
			sem_level[i]   = '0;
			waiter_head[i] = 0;
			waiter_fill[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_queue_full();
		test_backpressure();
		test_random();
		test_bank_exhausted();

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/csq_pkg.sv
hw/rtl/csq_ram.sv
hw/rtl/csq_ctrl.sv
hw/rtl/csq_dp.sv
hw/rtl/counting_semaphore_wait_queue.sv
verif/tb_counting_semaphore_wait_queue.sv
